### rtl/hgs_pkg.sv
package hgs_pkg;

  // Command codes carried in the low bits of the input tdata
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } hgs_op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_HEATER_TEMP  = 2'd0;
  localparam logic [1:0] CFG_HEATER_FIRST = 2'd1;
  localparam logic [1:0] CFG_HEATER_LAST  = 2'd2;
  localparam logic [1:0] CFG_SWEEP_COUNT  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_HEATER_TEMP  = 8'd200;
  localparam logic [7:0]  RST_HEATER_FIRST = 8'd40;
  localparam logic [7:0]  RST_HEATER_LAST  = 8'd59;
  localparam logic [15:0] RST_SWEEP_COUNT  = 16'd100;

  // Q8.8 temperature and the sum of four of them
  localparam int TEMP_W = 16;
  localparam int SUM_W  = TEMP_W + 2;

  typedef struct packed {
    logic [7:0]  heater_temp;
    logic [7:0]  heater_first_col;
    logic [7:0]  heater_last_col;
    logic [15:0] sweep_count;
  } hgs_cfg_t;

  // Heater level in Q8.8
  function automatic logic [TEMP_W-1:0] heater_value(input hgs_cfg_t cfg);
    heater_value = {cfg.heater_temp, 8'h00};
  endfunction

endpackage

### rtl/hgs_ram.sv
module hgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/hgs_sweep.sv
module hgs_sweep
  import hgs_pkg::*;
#(
  parameter int SIDE = 128,
  localparam int AW = $clog2(SIDE * SIDE)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hgs_cfg_t          cfg,
  output logic [AW-1:0]     raddr_a,
  input  logic [TEMP_W-1:0] rdata_a,
  output logic [AW-1:0]     raddr_b,
  input  logic [TEMP_W-1:0] rdata_b,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [TEMP_W-1:0] wdata,
  output logic              busy,
  output logic              done
);

  localparam int KW = $clog2((SIDE + 1) * SIDE);
  localparam int JW = $clog2(SIDE);
  localparam int PW = $clog2(SIDE + 1);
  localparam int CW = ($clog2(SIDE + 2) > 8) ? $clog2(SIDE + 2) : 8;

  // Issue stage: pass p = 0 only primes the line buffer with row 1,
  // pass p >= 1 relaxes interior row p.
  logic          run;
  logic [KW-1:0] k;
  logic [PW-1:0] p;
  logic [JW-1:0] j;
  logic          last_issue;
  logic [CW-1:0] wall_col;
  logic          heat;
  logic [JW-1:0] buf_raddr;

  // Data stage
  logic              d_v;
  logic              d_nwall;
  logic              d_heat;
  logic              d_swall;
  logic              d_ewall;
  logic              d_wfirst;
  logic              d_gwr;
  logic              d_bwr;
  logic              d_last;
  logic [AW-1:0]     d_waddr;
  logic [JW-1:0]     d_j;
  logic [TEMP_W-1:0] wreg;
  logic [TEMP_W-1:0] buf_q;
  logic [TEMP_W-1:0] n_val;
  logic [TEMP_W-1:0] s_val;
  logic [TEMP_W-1:0] e_val;
  logic [TEMP_W-1:0] w_val;
  logic [SUM_W-1:0]  sum;
  logic [TEMP_W-1:0] val;

  assign last_issue = (p == PW'(SIDE)) && (j == JW'(SIDE - 1));
  assign wall_col   = CW'(j) + CW'(1);
  assign heat       = (wall_col >= CW'(cfg.heater_first_col)) &&
                      (wall_col <= CW'(cfg.heater_last_col));
  assign buf_raddr  = j + JW'(1);

  // North from the row already written this sweep, south from the old row below
  assign raddr_a = AW'(k - KW'(2 * SIDE));
  assign raddr_b = AW'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      d_v <= 1'b0;
      k   <= '0;
      p   <= '0;
      j   <= '0;
    end else begin
      d_v <= run;
      if (start) begin
        run <= 1'b1;
        k   <= '0;
        p   <= '0;
        j   <= '0;
      end else if (run) begin
        k <= k + KW'(1);
        if (j == JW'(SIDE - 1)) begin
          j <= '0;
          p <= p + PW'(1);
        end else begin
          j <= j + JW'(1);
        end
        if (last_issue) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    d_nwall  <= (p == PW'(1));
    d_heat   <= heat;
    d_swall  <= (p == PW'(SIDE));
    d_ewall  <= (j == JW'(SIDE - 1));
    d_wfirst <= (j == '0);
    d_gwr    <= (p != '0);
    d_bwr    <= (p != PW'(SIDE));
    d_last   <= last_issue;
    d_waddr  <= AW'(k - KW'(SIDE));
    d_j      <= j;
    if (d_v) begin
      wreg <= val;
    end
  end

  // Line buffer: old values of the row below, read back one row later as east
  hgs_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (SIDE)
  ) u_line (
    .clk     (clk),
    .we      (d_v && d_bwr),
    .waddr   (d_j),
    .wdata   (rdata_b),
    .raddr_a (buf_raddr),
    .rdata_a (buf_q),
    .raddr_b ('0),
    .rdata_b ()
  );

  always_comb begin
    n_val = d_nwall ? (d_heat ? heater_value(cfg) : '0) : rdata_a;
    s_val = d_swall  ? '0 : rdata_b;
    e_val = d_ewall  ? '0 : buf_q;
    w_val = d_wfirst ? '0 : wreg;
    sum   = SUM_W'(n_val) + SUM_W'(s_val) + SUM_W'(e_val) + SUM_W'(w_val);
    val   = sum[SUM_W-1:2];
  end

  assign we    = d_v && d_gwr;
  assign waddr = d_waddr;
  assign wdata = val;
  assign busy  = run || d_v;
  assign done  = d_v && d_last;

endmodule

### rtl/heat_grid_gauss_seidel.sv
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  tdata: opcode[1:0], row[9:2], col[17:10]
// m        out  m_tvalid/m_tready  tdata: temperature[15:0], done_res[16]
// cfg      in   cfg_we             cfg_index selects register, cfg_data value
//
// Clear zeroes every cell; a read of an interior cell goes through the grid
// memory, any other command finishes directly. A run performs sweep_count
// sweeps: the stencil handles one cell per cycle, bound by the single grid
// write port, and each sweep adds one priming row that loads the line buffer.
// After reset the grid is zeroed by a pass over all SIDE*SIDE cells; s_tready
// stays low meanwhile. One command is in work at a time; a result waiting
// in the output register stalls only the finish of the next command.
module heat_grid_gauss_seidel
  import hgs_pkg::*;
#(
  parameter int SIDE = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode, row, col
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // temperature, done_res
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = ($clog2(SIDE + 2) > 8) ? $clog2(SIDE + 2) : 8;
  localparam int MW    = AW + 8;

  typedef enum logic [2:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CLEAR,
    ST_SWEEP_START,
    ST_SWEEP_WAIT,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  state_t            state;
  hgs_cfg_t          cfg;
  logic [15:0]       sweeps_left;
  logic [7:0]        cell_row;
  logic [7:0]        cell_col;
  logic [AW-1:0]     clr_addr;
  logic [TEMP_W-1:0] res_temp;
  logic              res_done;

  // Input decode
  hgs_op_t       in_op;
  logic [7:0]    in_row;
  logic [7:0]    in_col;
  logic [CW-1:0] in_row_w;
  logic [CW-1:0] in_col_w;
  logic          in_range;
  logic          in_wall;
  logic          in_heat;

  // Grid memory ports
  logic              grid_we;
  logic [AW-1:0]     grid_waddr;
  logic [TEMP_W-1:0] grid_wdata;
  logic [AW-1:0]     grid_raddr_a;
  logic [TEMP_W-1:0] grid_rdata_a;
  logic [AW-1:0]     grid_raddr_b;
  logic [TEMP_W-1:0] grid_rdata_b;

  // Sweep engine
  logic              sweep_start;
  logic              sweep_busy;
  logic              sweep_done;
  logic              sw_we;
  logic [AW-1:0]     sw_waddr;
  logic [TEMP_W-1:0] sw_wdata;
  logic [AW-1:0]     sw_raddr_a;
  logic [AW-1:0]     sw_raddr_b;

  logic [MW-1:0]     rd_lin;
  logic [AW-1:0]     rd_cell_addr;

  assign in_op    = hgs_op_t'(s_tdata[1:0]);
  assign in_row   = s_tdata[9:2];
  assign in_col   = s_tdata[17:10];
  assign in_row_w = CW'(in_row);
  assign in_col_w = CW'(in_col);
  assign in_range = (in_row_w <= CW'(SIDE + 1)) && (in_col_w <= CW'(SIDE + 1));
  assign in_wall  = (in_row_w == '0) || (in_row_w == CW'(SIDE + 1)) ||
                    (in_col_w == '0) || (in_col_w == CW'(SIDE + 1));
  // Only the north wall carries the heater, corners included
  assign in_heat  = (in_row_w == '0) &&
                    (in_col >= cfg.heater_first_col) && (in_col <= cfg.heater_last_col);

  assign s_tready    = (state == ST_IDLE);
  assign sweep_start = (state == ST_SWEEP_START);

  // Interior cell (row, col) sits at (row-1)*SIDE + (col-1)
  assign rd_lin       = MW'(cell_row - 8'd1) * MW'(SIDE) + MW'(cell_col - 8'd1);
  assign rd_cell_addr = rd_lin[AW-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heater_temp      <= RST_HEATER_TEMP;
      cfg.heater_first_col <= RST_HEATER_FIRST;
      cfg.heater_last_col  <= RST_HEATER_LAST;
      cfg.sweep_count      <= RST_SWEEP_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEATER_TEMP:  cfg.heater_temp      <= cfg_data[7:0];
        CFG_HEATER_FIRST: cfg.heater_first_col <= cfg_data[7:0];
        CFG_HEATER_LAST:  cfg.heater_last_col  <= cfg_data[7:0];
        CFG_SWEEP_COUNT:  cfg.sweep_count      <= cfg_data;
      endcase
    end
  end

  // Grid port arbitration: clear pass, read command, otherwise the sweep engine
  always_comb begin
    grid_we      = sw_we;
    grid_waddr   = sw_waddr;
    grid_wdata   = sw_wdata;
    grid_raddr_a = sw_raddr_a;
    grid_raddr_b = sw_raddr_b;
    if (state == ST_INIT_CLR || state == ST_CLEAR) begin
      grid_we    = 1'b1;
      grid_waddr = clr_addr;
      grid_wdata = '0;
    end
    if (state == ST_RD_ISSUE) begin
      grid_raddr_a = rd_cell_addr;
    end
  end

  // Command sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT_CLR;
      clr_addr    <= '0;
      sweeps_left <= '0;
      cell_row    <= '0;
      cell_col    <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // Drop the result once transferred, unless the next one is loaded now
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_INIT_CLR: begin
          if (clr_addr == AW'(CELLS - 1)) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            unique case (in_op)
              OP_CLEAR: begin
                res_temp <= '0;
                res_done <= 1'b1;
                clr_addr <= '0;
                state    <= ST_CLEAR;
              end
              OP_RUN: begin
                res_temp    <= '0;
                res_done    <= 1'b1;
                sweeps_left <= cfg.sweep_count;
                if (cfg.sweep_count == '0) begin
                  state <= ST_FINISH;
                end else begin
                  state <= ST_SWEEP_START;
                end
              end
              OP_READ: begin
                res_done <= 1'b1;
                cell_row <= in_row;
                cell_col <= in_col;
                if (!in_range) begin
                  res_temp <= '0;
                  state    <= ST_FINISH;
                end else if (in_wall) begin
                  res_temp <= in_heat ? heater_value(cfg) : '0;
                  state    <= ST_FINISH;
                end else begin
                  state <= ST_RD_ISSUE;
                end
              end
              default: begin
                // Unused code: no effect, not done
                res_temp <= '0;
                res_done <= 1'b0;
                state    <= ST_FINISH;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (clr_addr == AW'(CELLS - 1)) begin
            clr_addr <= '0;
            state    <= ST_FINISH;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_SWEEP_START: begin
          state <= ST_SWEEP_WAIT;
        end
        ST_SWEEP_WAIT: begin
          if (sweep_done) begin
            sweeps_left <= sweeps_left - 16'd1;
            if (sweeps_left == 16'd1) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SWEEP_START;
            end
          end
        end
        ST_RD_ISSUE: begin
          state <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          res_temp <= grid_rdata_a;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res_done, res_temp};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  hgs_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk     (clk),
    .we      (grid_we),
    .waddr   (grid_waddr),
    .wdata   (grid_wdata),
    .raddr_a (grid_raddr_a),
    .rdata_a (grid_rdata_a),
    .raddr_b (grid_raddr_b),
    .rdata_b (grid_rdata_b)
  );

  hgs_sweep #(
    .SIDE (SIDE)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (sweep_start),
    .cfg     (cfg),
    .raddr_a (sw_raddr_a),
    .rdata_a (grid_rdata_a),
    .raddr_b (sw_raddr_b),
    .rdata_b (grid_rdata_b),
    .we      (sw_we),
    .waddr   (sw_waddr),
    .wdata   (sw_wdata),
    .busy    (sweep_busy),
    .done    (sweep_done)
  );

`ifndef SYNTHESIS
  a_ready_not_sweeping: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sweep_busy)
    else $error("input ready while the sweep engine is busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sweep_done |-> (state == ST_SWEEP_WAIT))
    else $error("sweep finished outside its wait state");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_ISSUE || state == ST_RD_WAIT) |-> !grid_we)
    else $error("grid written during a cell read");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
    else $error("finished command did not reach the output register");
`endif

endmodule

### bench/tb_heat_grid_gauss_seidel.sv
module tb_heat_grid_gauss_seidel;
  import hgs_pkg::*;

  // Room size of the instance under test; walls add one cell on every side
  localparam int GRID_SIDE = 128;
  localparam int WALL_MAX  = GRID_SIDE + 1;

  // Opcode that the block must ignore apart from a zero, not-done result
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Caps on the slow commands in the random part: sweeps and clears each
  // visit every cell of the room, so keep their count bounded
  localparam int SWEEP_BUDGET = 30;
  localparam int CLEAR_BUDGET = 8;

  // Watchdog: several times the slowest correct run (reset pass, every
  // budgeted sweep and clear, every stall), in cycles of a 12-unit clock
  localparam int WATCHDOG_CYCLES = 3_000_000;

  // Cycles to linger once nothing is expected; covers the longest quick
  // command plus margin, so a stray extra result is still caught
  localparam int SETTLE_CYCLES = 50;

  typedef struct packed {
    logic [15:0] temperature;
    logic        done;
  } reading_t;

  // Bit-exact model of the room: holds the interior, the heater setting and
  // the readings still owed by the block
  class room_model;
    bit [15:0] cells [GRID_SIDE*GRID_SIDE];
    bit [7:0]  heat_level;
    bit [7:0]  heat_first;
    bit [7:0]  heat_last;
    bit [15:0] sweeps_per_run;
    reading_t  expected_readings [$];
    int        mismatches;
    int        readings_checked;
    int        sweeps_done;
    int        cmd_count [4];

    function new();
      foreach (cells[i]) cells[i] = '0;
      heat_level     = RST_HEATER_TEMP;
      heat_first     = RST_HEATER_FIRST;
      heat_last      = RST_HEATER_LAST;
      sweeps_per_run = RST_SWEEP_COUNT;
      mismatches     = 0;
      readings_checked = 0;
      sweeps_done    = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] val);
      case (idx)
        CFG_HEATER_TEMP:  heat_level     = val[7:0];
        CFG_HEATER_FIRST: heat_first     = val[7:0];
        CFG_HEATER_LAST:  heat_last      = val[7:0];
        CFG_SWEEP_COUNT:  sweeps_per_run = val;
        default: ;
      endcase
    endfunction

    // Value of any cell, walls included, rows and columns 0..SIDE+1
    function bit [15:0] cell_value(input int r, input int c);
      if (r == 0)
        return (c >= heat_first && c <= heat_last) ? {heat_level, 8'h00} : 16'h0000;
      if (r > GRID_SIDE || c == 0 || c > GRID_SIDE)
        return 16'h0000;
      return cells[(r - 1) * GRID_SIDE + (c - 1)];
    endfunction

    // One in-place pass, row by row, left to right; later cells see the
    // values already updated in this pass
    function void relax_once();
      bit [17:0] total;
      for (int r = 1; r <= GRID_SIDE; r++) begin
        for (int c = 1; c <= GRID_SIDE; c++) begin
          total = 18'(cell_value(r - 1, c)) + 18'(cell_value(r + 1, c))
                + 18'(cell_value(r, c - 1)) + 18'(cell_value(r, c + 1));
          cells[(r - 1) * GRID_SIDE + (c - 1)] = total[17:2];
        end
      end
      sweeps_done++;
    endfunction

    // Note an accepted command and queue the reading it must produce
    function void take_command(input logic [1:0] op, input logic [7:0] r,
                               input logic [7:0] c);
      reading_t owed;
      owed = '0;
      case (op)
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = '0;
          owed.done = 1'b1;
        end
        OP_RUN: begin
          repeat (sweeps_per_run) relax_once();
          owed.done = 1'b1;
        end
        OP_READ: begin
          if (r <= WALL_MAX && c <= WALL_MAX)
            owed.temperature = cell_value(r, c);
          owed.done = 1'b1;
        end
        default: ;
      endcase
      cmd_count[op]++;
      expected_readings.push_back(owed);
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, want %0d (reading %0d)",
               what, got, want, readings_checked);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest owed reading
    task check_reading(input logic [23:0] word);
      reading_t owed;
      readings_checked++;
      if (expected_readings.size() == 0) begin
        report_mismatch("result with nothing owed, temperature", word[15:0], 0);
        return;
      end
      owed = expected_readings.pop_front();
      if (word[15:0] !== owed.temperature)
        report_mismatch("temperature", word[15:0], owed.temperature);
      if (word[16] !== owed.done)
        report_mismatch("done_res", word[16], owed.done);
    endtask
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;   // opcode[1:0], row[9:2], col[17:10]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;          // temperature[15:0], done_res[16]
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  room_model sb;
  int src_idle_pct  = 27;
  int sink_idle_pct = 63;
  int sweeps_issued = 0;
  int clears_issued = 0;

  heat_grid_gauss_seidel #(.SIDE(GRID_SIDE)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    #(12 * WATCHDOG_CYCLES);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver and monitors. Values read just after the edge are those the
  // block saw at the edge, so a transfer is exactly valid && ready here.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
      if (m_tvalid && m_tready)
        sb.check_reading(m_tdata);
      if (s_tvalid && s_tready)
        sb.take_command(s_tdata[1:0], s_tdata[9:2], s_tdata[17:10]);
    end
  end

  // Offer one command and hold it until the transfer; idle first at random.
  // tvalid is assigned once per step, so a held valid never dips.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, c, r, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait until every owed reading has come back; waiting for
  // the falling edge lets the monitor note a transfer made at the last edge first
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_one(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Load all four registers back to back; only call while the block is idle
  task automatic load_regs(input logic [7:0] level, input logic [7:0] first,
                           input logic [7:0] last, input logic [15:0] sweeps);
    write_one(CFG_HEATER_TEMP, {8'd0, level});
    write_one(CFG_HEATER_FIRST, {8'd0, first});
    write_one(CFG_HEATER_LAST, {8'd0, last});
    write_one(CFG_SWEEP_COUNT, sweeps);
    cfg_we <= 1'b0;
  endtask

  // Mostly reads, biased towards the rows near the heater where the heat
  // actually spreads; a few runs and clears, some unused opcodes and
  // addresses beyond the walls as noise
  task automatic random_phase(input int n_items);
    int pick;
    int shape;
    logic [7:0] r;
    logic [7:0] c;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 12 && sweeps_issued + sb.sweeps_per_run <= SWEEP_BUDGET) begin
        sweeps_issued += sb.sweeps_per_run;
        send_cmd(OP_RUN, 8'($urandom), 8'($urandom));
      end else if (pick < 18 && clears_issued < CLEAR_BUDGET) begin
        clears_issued++;
        send_cmd(OP_CLEAR, 8'($urandom), 8'($urandom));
      end else if (pick < 24) begin
        send_cmd(OP_UNUSED, 8'($urandom), 8'($urandom));
      end else begin
        shape = $urandom_range(99);
        if (shape < 15) begin
          r = 8'($urandom);
          c = 8'($urandom);
        end else if (shape < 60) begin
          r = 8'($urandom_range(0, 6));
          c = 8'($urandom_range(0, WALL_MAX));
        end else begin
          r = 8'($urandom_range(0, WALL_MAX));
          c = 8'($urandom_range(0, WALL_MAX));
        end
        send_cmd(OP_READ, r, c);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: heater edges, walls, corners, beyond the walls, unused op
    send_cmd(OP_READ, 8'd0, 8'd40);
    send_cmd(OP_READ, 8'd0, 8'd39);
    send_cmd(OP_READ, 8'd0, 8'd59);
    send_cmd(OP_READ, 8'd0, 8'd60);
    send_cmd(OP_READ, 8'd1, 8'd1);
    send_cmd(OP_READ, 8'(WALL_MAX), 8'(WALL_MAX));
    send_cmd(OP_READ, 8'(WALL_MAX + 1), 8'd5);
    send_cmd(OP_READ, 8'd5, 8'd255);
    send_cmd(OP_UNUSED, 8'd255, 8'd255);
    drain();

    // Hottest heater across the whole north wall, corners included; a run
    // with no sweeps must still report done and leave the room cold
    load_regs(8'd255, 8'd0, 8'(WALL_MAX), 16'd0);
    send_cmd(OP_READ, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd0, 8'(WALL_MAX));
    send_cmd(OP_RUN, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd1, 8'd64);
    drain();

    // Single sweeps: first row warms, far corner stays cold
    load_regs(8'd255, 8'd0, 8'(WALL_MAX), 16'd1);
    send_cmd(OP_RUN, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd1, 8'd1);
    send_cmd(OP_READ, 8'd1, 8'd128);
    send_cmd(OP_RUN, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd2, 8'd64);
    send_cmd(OP_READ, 8'd128, 8'd128);
    send_cmd(OP_CLEAR, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd1, 8'd1);
    drain();

    // Cold heater, then an empty heater range; the top sweep count is
    // loaded but never run
    load_regs(8'd0, 8'd0, 8'(WALL_MAX), 16'hFFFF);
    send_cmd(OP_READ, 8'd0, 8'd0);
    drain();
    load_regs(8'd77, 8'd90, 8'd10, 16'hFFFF);
    send_cmd(OP_READ, 8'd0, 8'd10);
    send_cmd(OP_READ, 8'd0, 8'd50);
    send_cmd(OP_READ, 8'd0, 8'd90);
    drain();

    // Random part, sender idling lightly and receiver heavily
    load_regs(8'($urandom_range(1, 255)), 8'($urandom_range(0, 70)),
              8'($urandom_range(70, WALL_MAX)), 16'($urandom_range(1, 3)));
    random_phase(26);
    drain();

    // Swap the idling; heater range running past the east wall
    src_idle_pct  = 63;
    sink_idle_pct = 27;
    load_regs(8'd255, 8'd100, 8'd255, 16'd2);
    random_phase(26);
    drain();

    // Full rate on both sides; any heater range, possibly empty
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, WALL_MAX)),
              8'($urandom_range(0, WALL_MAX)), 16'($urandom_range(1, 3)));
    random_phase(26);

    // Wait out the last readings, then linger to catch strays
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_readings.size() != 0)
      sb.report_mismatch("readings never delivered", 0, sb.expected_readings.size());

    $display("covered %0d clears, %0d runs (%0d sweeps), %0d reads, %0d unused opcodes",
             sb.cmd_count[OP_CLEAR], sb.cmd_count[OP_RUN], sb.sweeps_done,
             sb.cmd_count[OP_READ], sb.cmd_count[OP_UNUSED]);
    $display("checked %0d readings, %0d mismatches", sb.readings_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
